FILE: hw/rtl/pei_pkg.sv
`timescale 1ns / 1ps

package pei_pkg;

    // Default geometry of the vertex stores
    localparam int MAX_VERTICES_DEF = 8;
    localparam int COORD_BITS_DEF   = 16;

    // Port widths fixed by the request format
    localparam int FUNC_W   = 3;
    localparam int FIELD_W  = 16;
    localparam int STATUS_W = 2;

    // Corners written by a rectangle load
    localparam int RECT_CORNERS = 4;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_RECT_A   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECT_B   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TEST     = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd2;

endpackage

FILE: hw/rtl/polygon_edge_intersection_test_top.sv
`timescale 1ns / 1ps

// Polygon edge intersection test. Two vertex stores, A and B, each hold up to
// MAX_VERTICES (x, y) pairs in a small two-read-port memory. A request is taken
// when start is high and busy is low; every request returns exactly one result,
// shown for one cycle with o_valid high, and the receiver cannot stall it.
// Appends, clear, unused function codes and tests with fewer than two vertices in
// either store answer in the cycle after the request and leave busy low, so a new
// request may follow at once. A non-degenerate rectangle load answers in the next
// cycle too but holds busy while the remaining corners go into the store through
// its single write port. A test holds busy while its edge pairs are scanned and
// the pipeline drains, and answers in the same cycle that busy drops: one edge
// pair is read per cycle, each memory supplying both end points of its edge, and
// the pair then moves through a difference stage, a product stage (six multipliers
// of COORD_BITS+1 bits) and a sum stage before the sign checks. Every pair is
// evaluated; the hit flag is the OR over all of them. Coordinates are taken as
// the low COORD_BITS bits of each 16-bit field. Vertex memories have no reset;
// only entries below the vertex count are ever read.

module polygon_edge_intersection_test_top
    import pei_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [FIELD_W-1:0]  i_x0,
    input  logic [FIELD_W-1:0]  i_y0,
    input  logic [FIELD_W-1:0]  i_x1,
    input  logic [FIELD_W-1:0]  i_y1,
    output logic                o_valid,
    output logic                o_intersect_res,
    output logic [STATUS_W-1:0] o_status
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;  // address bits
    localparam int CW = $clog2(MAX_VERTICES + 1);                        // count bits
    localparam int VW = 2 * COORD_BITS;                                  // packed vertex
    localparam int DW = COORD_BITS + 1;                                  // difference
    localparam int PW = 2 * DW;                                          // product
    localparam int SW = PW + 1;                                          // cross product

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RECT  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    typedef logic [VW-1:0] t_vertex;

    // Rectangle corner k from two diagonal corners, in store order
    function automatic t_vertex corner(input logic [1:0] k,
                                       input logic [COORD_BITS-1:0] x0,
                                       input logic [COORD_BITS-1:0] y0,
                                       input logic [COORD_BITS-1:0] x1,
                                       input logic [COORD_BITS-1:0] y1);
        t_vertex v;
        case (k)
            2'd0:    v = {x0, y0};
            2'd1:    v = {x0, y1};
            2'd2:    v = {x1, y1};
            default: v = {x1, y0};
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count_a, n_count_a;
    logic [CW-1:0]   r_count_b, n_count_b;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    logic [1:0]      r_wk, n_wk;
    logic            r_hit, n_hit;
    logic            r_valid, n_valid;
    logic            r_res, n_res;
    logic [STATUS_W-1:0] r_status, n_status;

    // Request payload held for the remaining rectangle corners
    logic [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic                  r_sel_b;

    // Vertex memories and their registered read data
    t_vertex r_mem_a [MAX_VERTICES];
    t_vertex r_mem_b [MAX_VERTICES];
    t_vertex r_rd_a0, r_rd_a1, r_rd_b0, r_rd_b1;

    // Pipeline tags: read, difference, product, sum
    logic r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid;
    logic r_p1_last,  r_p2_last,  r_p3_last,  r_p4_last;

    logic signed [DW-1:0] r_abx, r_aby, r_cdx, r_cdy, r_acx, r_acy;
    logic signed [PW-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [SW-1:0] r_den, r_n1, r_n2;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                  accept;
    logic [COORD_BITS-1:0] cx0, cy0, cx1, cy1;
    logic                  degen;

    assign accept = start && !busy;
    assign cx0    = COORD_BITS'($unsigned(i_x0));
    assign cy0    = COORD_BITS'($unsigned(i_y0));
    assign cx1    = COORD_BITS'($unsigned(i_x1));
    assign cy1    = COORD_BITS'($unsigned(i_y1));
    assign degen  = (cx0 == cx1) && (cy0 == cy1);

    // ------------------------------------------------------------------
    // Scan indices: edge i -> i2 of A against edge j -> j2 of B
    // ------------------------------------------------------------------
    logic [CW-1:0] i_inc, j_inc;
    logic          wrap_i, wrap_j;
    logic [IW-1:0] ai2, bj2;
    logic          scan_last;

    assign i_inc     = CW'(r_i) + CW'(1);
    assign j_inc     = CW'(r_j) + CW'(1);
    assign wrap_i    = (i_inc == r_count_a);
    assign wrap_j    = (j_inc == r_count_b);
    assign ai2       = wrap_i ? '0 : i_inc[IW-1:0];
    assign bj2       = wrap_j ? '0 : j_inc[IW-1:0];
    assign scan_last = wrap_i && wrap_j;

    // ------------------------------------------------------------------
    // Edge pair decision on the sum stage
    // ------------------------------------------------------------------
    logic meet;
    logic n1_in, n2_in;

    always_comb begin
        if (r_den > 0) begin
            n1_in = (r_n1 >= 0) && (r_n1 <= r_den);
            n2_in = (r_n2 >= 0) && (r_n2 <= r_den);
        end else begin
            n1_in = (r_n1 <= 0) && (r_n1 >= r_den);
            n2_in = (r_n2 <= 0) && (r_n2 >= r_den);
        end
        if (r_den == 0) begin
            meet = (r_n1 == 0) && (r_n2 == 0);
        end else begin
            meet = n1_in && n2_in;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic          we_a, we_b, issue;
    logic [IW-1:0] waddr;
    t_vertex       wdata;

    always_comb begin
        n_state   = r_state;
        n_count_a = r_count_a;
        n_count_b = r_count_b;
        n_i       = r_i;
        n_j       = r_j;
        n_wk      = r_wk;
        n_hit     = r_hit;
        n_valid   = 1'b0;
        n_res     = 1'b0;
        n_status  = STATUS_OK;
        we_a      = 1'b0;
        we_b      = 1'b0;
        waddr     = '0;
        wdata     = {cx0, cy0};
        issue     = 1'b0;

        // accumulate any pair that meets
        if (r_p4_valid && meet) begin
            n_hit = 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid = 1'b1;
                    case (i_func)
                        FUNC_RECT_A, FUNC_RECT_B: begin
                            if (degen) begin
                                n_status = STATUS_DEGEN;
                            end else begin
                                we_a  = (i_func == FUNC_RECT_A);
                                we_b  = (i_func == FUNC_RECT_B);
                                waddr = '0;
                                wdata = corner(2'd0, cx0, cy0, cx1, cy1);
                                if (i_func == FUNC_RECT_A) begin
                                    n_count_a = CW'(RECT_CORNERS);
                                end else begin
                                    n_count_b = CW'(RECT_CORNERS);
                                end
                                n_wk    = 2'd1;
                                n_state = ST_RECT;
                            end
                        end
                        FUNC_APPEND_A: begin
                            if (r_count_a == CW'(MAX_VERTICES)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                we_a      = 1'b1;
                                waddr     = r_count_a[IW-1:0];
                                n_count_a = r_count_a + CW'(1);
                            end
                        end
                        FUNC_APPEND_B: begin
                            if (r_count_b == CW'(MAX_VERTICES)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                we_b      = 1'b1;
                                waddr     = r_count_b[IW-1:0];
                                n_count_b = r_count_b + CW'(1);
                            end
                        end
                        FUNC_TEST: begin
                            if (r_count_a >= CW'(2) && r_count_b >= CW'(2)) begin
                                // answer comes at the end of the scan
                                n_valid = 1'b0;
                                n_hit   = 1'b0;
                                n_i     = '0;
                                n_j     = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count_a = '0;
                            n_count_b = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RECT: begin
                we_a  = !r_sel_b;
                we_b  = r_sel_b;
                waddr = IW'(r_wk);
                wdata = corner(r_wk, r_x0, r_y0, r_x1, r_y1);
                n_wk  = r_wk + 2'd1;
                if (r_wk == 2'(RECT_CORNERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                issue = 1'b1;
                if (wrap_j) begin
                    n_j = '0;
                    n_i = ai2;
                end else begin
                    n_j = bj2;
                end
                if (scan_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (r_p4_valid && r_p4_last) begin
                    n_valid = 1'b1;
                    n_res   = r_hit || meet;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count_a  <= '0;
            r_count_b  <= '0;
            r_valid    <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count_a  <= n_count_a;
            r_count_b  <= n_count_b;
            r_valid    <= n_valid;
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_wk     <= n_wk;
        r_hit    <= n_hit;
        r_res    <= n_res;
        r_status <= n_status;
        if (accept) begin
            r_x0    <= cx0;
            r_y0    <= cy0;
            r_x1    <= cx1;
            r_y1    <= cy1;
            r_sel_b <= (i_func == FUNC_RECT_B);
        end
        r_p1_last <= scan_last;
        r_p2_last <= r_p1_last;
        r_p3_last <= r_p2_last;
        r_p4_last <= r_p3_last;
    end

    // ------------------------------------------------------------------
    // Vertex memories: one write port, two registered read ports each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[waddr] <= wdata;
        end
        if (issue) begin
            r_rd_a0 <= r_mem_a[r_i];
            r_rd_a1 <= r_mem_a[ai2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[waddr] <= wdata;
        end
        if (issue) begin
            r_rd_b0 <= r_mem_b[r_j];
            r_rd_b1 <= r_mem_b[bj2];
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic pipeline: differences, products, cross products
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    assign ax = $signed(r_rd_a0[VW-1:COORD_BITS]);
    assign ay = $signed(r_rd_a0[COORD_BITS-1:0]);
    assign bx = $signed(r_rd_a1[VW-1:COORD_BITS]);
    assign by = $signed(r_rd_a1[COORD_BITS-1:0]);
    assign cx = $signed(r_rd_b0[VW-1:COORD_BITS]);
    assign cy = $signed(r_rd_b0[COORD_BITS-1:0]);
    assign dx = $signed(r_rd_b1[VW-1:COORD_BITS]);
    assign dy = $signed(r_rd_b1[COORD_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        r_abx <= DW'(bx) - DW'(ax);
        r_aby <= DW'(by) - DW'(ay);
        r_cdx <= DW'(dx) - DW'(cx);
        r_cdy <= DW'(dy) - DW'(cy);
        r_acx <= DW'(ax) - DW'(cx);
        r_acy <= DW'(ay) - DW'(cy);

        r_m0 <= r_abx * r_cdy;
        r_m1 <= r_aby * r_cdx;
        r_m2 <= r_acy * r_cdx;
        r_m3 <= r_acx * r_cdy;
        r_m4 <= r_acy * r_abx;
        r_m5 <= r_acx * r_aby;

        r_den <= SW'(r_m0) - SW'(r_m1);
        r_n1  <= SW'(r_m2) - SW'(r_m3);
        r_n2  <= SW'(r_m4) - SW'(r_m5);
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_intersect_res = r_res;
    assign o_status        = r_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_a <= CW'(MAX_VERTICES))
        else $error("vertex count of store A above capacity");

    a_count_b_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_b <= CW'(MAX_VERTICES))
        else $error("vertex count of store B above capacity");

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_func == FUNC_TEST && r_count_a >= CW'(2) && r_count_b >= CW'(2))
        |=> (busy && !o_valid))
        else $error("test with edges did not enter the scan");

    a_last_pair_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p4_valid && r_p4_last) |=> (o_valid && !busy))
        else $error("last edge pair did not produce a result");

    a_hit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_intersect_res) |-> (o_status == STATUS_OK))
        else $error("intersection reported with a non-ok status");

endmodule

FILE: sim/polygon_edge_intersection_test_top_test.sv
`timescale 1ns / 1ps

module polygon_edge_intersection_test_top_test;
    import pei_pkg::*;

    localparam int NV             = MAX_VERTICES_DEF;
    localparam int CW             = COORD_BITS_DEF;
    // Longest quiet stretch: a full test over two full stores, plus a sender gap.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = NV * NV + 16;

    localparam int STORE_A = 0;
    localparam int STORE_B = 1;

    // Codes the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    typedef struct packed {
        logic                hit;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [FIELD_W-1:0]  i_x0;
    logic [FIELD_W-1:0]  i_y0;
    logic [FIELD_W-1:0]  i_x1;
    logic [FIELD_W-1:0]  i_y1;
    logic                o_valid;
    logic                o_intersect_res;
    logic [STATUS_W-1:0] o_status;

    // Shadow copy of both vertex stores
    logic signed [CW-1:0] vert_x [2][NV];
    logic signed [CW-1:0] vert_y [2][NV];
    int unsigned          vert_count [2];

    outcome_t    pending_outcomes [$];
    outcome_t    due_outcome;
    int unsigned requests_taken = 0;
    int unsigned sent_items     = 0;
    int unsigned failures       = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned idle_pct       = 0;

    polygon_edge_intersection_test_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_x0            (i_x0),
        .i_y0            (i_y0),
        .i_x1            (i_x1),
        .i_y1            (i_y1),
        .o_valid         (o_valid),
        .o_intersect_res (o_intersect_res),
        .o_status        (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Exact edge geometry: cross products in 64 bits, no division
    // ---------------------------------------------------------------------

    function automatic bit within_unit(longint n, longint den);
        if (den > 0)
            return (n >= 0) && (n <= den);
        return (n <= 0) && (n >= den);
    endfunction

    function automatic bit edges_cross(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy);
        longint abx, aby, cdx, cdy, acx, acy, den, n1, n2;
        abx = bx - ax;
        aby = by - ay;
        cdx = dx - cx;
        cdy = dy - cy;
        acx = ax - cx;
        acy = ay - cy;
        den = abx * cdy - aby * cdx;
        n1  = acy * cdx - acx * cdy;
        n2  = acy * abx - acx * aby;
        // Parallel edges meet only when collinear, overlap or not
        if (den == 0)
            return (n1 == 0) && (n2 == 0);
        return within_unit(n1, den) && within_unit(n2, den);
    endfunction

    // Walk every closed edge of A against every closed edge of B
    function automatic bit polygons_cross();
        int unsigned i, j, i2, j2;
        if (vert_count[STORE_A] < 2 || vert_count[STORE_B] < 2)
            return 1'b0;
        for (i = 0; i < vert_count[STORE_A]; i++) begin
            i2 = (i + 1 == vert_count[STORE_A]) ? 0 : i + 1;
            for (j = 0; j < vert_count[STORE_B]; j++) begin
                j2 = (j + 1 == vert_count[STORE_B]) ? 0 : j + 1;
                if (edges_cross(vert_x[STORE_A][i], vert_y[STORE_A][i],
                                vert_x[STORE_A][i2], vert_y[STORE_A][i2],
                                vert_x[STORE_B][j], vert_y[STORE_B][j],
                                vert_x[STORE_B][j2], vert_y[STORE_B][j2]))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow stores and return the result it must give
    function automatic outcome_t apply_request(logic [FUNC_W-1:0] func,
                                               logic signed [CW-1:0] x0, logic signed [CW-1:0] y0,
                                               logic signed [CW-1:0] x1, logic signed [CW-1:0] y1);
        outcome_t r;
        int       s;
        r = '0;
        s = (func == FUNC_RECT_B || func == FUNC_APPEND_B) ? STORE_B : STORE_A;
        case (func)
            FUNC_RECT_A, FUNC_RECT_B: begin
                if (x0 == x1 && y0 == y1) begin
                    r.status = STATUS_DEGEN;
                end else begin
                    vert_x[s][0] = x0; vert_y[s][0] = y0;
                    vert_x[s][1] = x0; vert_y[s][1] = y1;
                    vert_x[s][2] = x1; vert_y[s][2] = y1;
                    vert_x[s][3] = x1; vert_y[s][3] = y0;
                    vert_count[s] = RECT_CORNERS;
                end
            end
            FUNC_APPEND_A, FUNC_APPEND_B: begin
                if (vert_count[s] >= NV) begin
                    r.status = STATUS_FULL;
                end else begin
                    vert_x[s][vert_count[s]] = x0;
                    vert_y[s][vert_count[s]] = y0;
                    vert_count[s]++;
                end
            end
            FUNC_TEST: begin
                r.hit = polygons_cross();
            end
            FUNC_CLEAR: begin
                vert_count[STORE_A] = 0;
                vert_count[STORE_B] = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: check results, record accepted requests, run the watchdog.
    // Everything here samples the values present just before the rising edge.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Check before recording, so a result is never matched to its own cycle
            if (o_valid) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    failures++;
                end else begin
                    due_outcome = pending_outcomes.pop_front();
                    if (o_intersect_res !== due_outcome.hit) begin
                        $error("intersect_res: expected %0d, got %0d",
                               due_outcome.hit, o_intersect_res);
                        failures++;
                    end
                    if (o_status !== due_outcome.status) begin
                        $error("status: expected %0d, got %0d",
                               due_outcome.status, o_status);
                        failures++;
                    end
                end
            end
            if (start && !busy) begin
                pending_outcomes.insert(pending_outcomes.size(),
                                        apply_request(i_func, i_x0, i_y0, i_x1, i_y1));
                requests_taken++;
            end
            // Count cycles in which neither side moves anything
            if (o_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Driving: all inputs change at the falling edge
    // ---------------------------------------------------------------------

    // Drop start for one cycle and put junk on the fields, which must be ignored
    task automatic idle_cycle();
        start  = 1'b0;
        i_func = FUNC_W'($urandom);
        i_x0   = FIELD_W'($urandom);
        i_y0   = FIELD_W'($urandom);
        i_x1   = FIELD_W'($urandom);
        i_y1   = FIELD_W'($urandom);
        @(negedge i_clk);
    endtask

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [FIELD_W-1:0] x0, input logic [FIELD_W-1:0] y0,
                                input logic [FIELD_W-1:0] x1, input logic [FIELD_W-1:0] y1);
        int unsigned taken_before;
        while ($urandom_range(99) < idle_pct)
            idle_cycle();
        taken_before = requests_taken;
        start  = 1'b1;
        i_func = func;
        i_x0   = x0;
        i_y0   = y0;
        i_x1   = x1;
        i_y1   = y1;
        do @(negedge i_clk); while (requests_taken == taken_before);
        sent_items++;
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_results();
        start = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly small coordinates so that edges actually meet
    function automatic logic [FIELD_W-1:0] pick_coord(bit wide);
        int v;
        if (wide)
            return FIELD_W'($urandom);
        v = int'($urandom_range(48)) - 24;
        return v[FIELD_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------------

    // Test with empty stores, then with a single vertex in each: no edges either way
    task automatic test_empty_stores();
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(FUNC_APPEND_A, 16'd5, 16'd5, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_APPEND_B, 16'd5, 16'd5, 16'h0000, 16'h0000);
        send_request(FUNC_TEST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Rectangle loads at the coordinate extremes, containment, degenerate diagonal,
    // shared corner and a zero-width rectangle lying on an edge
    task automatic test_rectangles();
        send_request(FUNC_RECT_A, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_request(FUNC_RECT_B, 16'd0, 16'd0, 16'd10, 16'd10);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(FUNC_RECT_A, 16'd7, 16'd7, 16'd7, 16'd7);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(FUNC_RECT_B, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_request(FUNC_RECT_B, 16'h7FFF, 16'hFFFB, 16'h7FFF, 16'h0005);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // A holds four corners; fill it to the top and push one more vertex past it
    task automatic test_store_full();
        send_request(FUNC_APPEND_A, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000);
        send_request(FUNC_APPEND_A, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_APPEND_A, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA);
        send_request(FUNC_APPEND_A, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555);
        send_request(FUNC_APPEND_A, 16'h1234, 16'hFEDC, 16'h0000, 16'h0000);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Collinear edges that do not overlap still count as meeting
    task automatic test_collinear_apart();
        send_request(FUNC_RECT_A, 16'd0, 16'd0, 16'd1, 16'd1);
        send_request(FUNC_RECT_B, 16'd5, 16'd0, 16'd6, 16'd1);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Two-vertex polygons on parallel, separate lines
    task automatic test_two_vertices();
        send_request(FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_APPEND_A, 16'd0, 16'd0, 16'h0000, 16'h0000);
        send_request(FUNC_APPEND_A, 16'd10, 16'd0, 16'h0000, 16'h0000);
        send_request(FUNC_APPEND_B, 16'd0, 16'd5, 16'h0000, 16'h0000);
        send_request(FUNC_APPEND_B, 16'd10, 16'd5, 16'h0000, 16'h0000);
        send_request(FUNC_TEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Unused codes answer with zeros and change nothing
    task automatic test_spare_codes();
        send_request(FUNC_SPARE_6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_SPARE_7, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // ---------------------------------------------------------------------
    // Random traffic
    // ---------------------------------------------------------------------

    // Load one store as a rectangle or as a run of appends (0 to NV+1 vertices)
    task automatic build_store(int s, bit wide);
        int unsigned n;
        logic [FIELD_W-1:0] x0, y0, x1, y1;
        if ($urandom_range(99) < 40) begin
            x0 = pick_coord(wide);
            y0 = pick_coord(wide);
            x1 = pick_coord(wide);
            y1 = pick_coord(wide);
            // Force a degenerate diagonal now and then
            if ($urandom_range(19) == 0) begin
                x1 = x0;
                y1 = y0;
            end
            send_request((s == STORE_A) ? FUNC_RECT_A : FUNC_RECT_B, x0, y0, x1, y1);
        end else begin
            n = $urandom_range(NV + 1);
            repeat (n)
                send_request((s == STORE_A) ? FUNC_APPEND_A : FUNC_APPEND_B,
                             pick_coord(wide), pick_coord(wide),
                             FIELD_W'($urandom), FIELD_W'($urandom));
        end
    endtask

    // Mostly clear/build/build/test sequences; the rest is raw noise on every code
    task automatic run_random_phase(int unsigned pct, int unsigned items);
        int unsigned goal;
        bit          wide;
        idle_pct = pct;
        goal = sent_items + items;
        while (sent_items < goal) begin
            if ($urandom_range(99) < 85) begin
                wide = ($urandom_range(9) == 0);
                if ($urandom_range(9) < 7)
                    send_request(FUNC_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom),
                                 FIELD_W'($urandom), FIELD_W'($urandom));
                build_store(STORE_A, wide);
                build_store(STORE_B, wide);
                send_request(FUNC_TEST, FIELD_W'($urandom), FIELD_W'($urandom),
                             FIELD_W'($urandom), FIELD_W'($urandom));
            end else begin
                send_request(FUNC_W'($urandom_range(7)), FIELD_W'($urandom),
                             FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
            end
            // Pause now and then until the block has answered everything
            if ($urandom_range(49) == 0)
                drain_results();
        end
    endtask

    // ---------------------------------------------------------------------
    // Sequence of the run
    // ---------------------------------------------------------------------

    initial begin
        // Drive every input from time zero and hold reset low, releasing it at a falling edge
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_func  = FUNC_CLEAR;
        i_x0    = '0;
        i_y0    = '0;
        i_x1    = '0;
        i_y1    = '0;
        vert_count[STORE_A] = 0;
        vert_count[STORE_B] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_stores();
        test_rectangles();
        test_store_full();
        test_collinear_apart();
        test_two_vertices();
        test_spare_codes();
        drain_results();

        // Sender idles 27 %, then 70 %, then not at all
        run_random_phase(27, 140);
        drain_results();
        run_random_phase(70, 140);
        run_random_phase(0, 140);

        // Wait out the last results, then let any stray strobe show up
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (failures == 0 && pending_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
